/* rtl/gha_pkg.sv */
// ----------------------------------------------------------------------------
// gha_pkg
// Types and constants shared by the generational handle allocator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package gha_pkg;

    localparam int unsigned SLOTS    = 1024;
    localparam int unsigned IDX_W    = 10;
    localparam int unsigned CNT_W    = 11;
    localparam int unsigned GEN_W    = 32;
    localparam int unsigned REF_W    = 32;
    localparam int unsigned STAT_W   = 3;

    typedef enum logic [1:0] {
        OP_REGISTER = 2'd0,
        OP_EXPIRE   = 2'd1,
        OP_LOOKUP   = 2'd2,
        OP_LOOKUP_ALT = 2'd3
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_BAD_INDEX = 3'd2,
        ST_STALE     = 3'd3,
        ST_OVERFLOW  = 3'd4
    } t_status;

    typedef struct packed {
        logic [1:0]       operation;
        logic [IDX_W-1:0] slot_index;
        logic [GEN_W-1:0] slot_version;
        logic [REF_W-1:0] object_ref;
    } t_cmd;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [IDX_W-1:0]  handle_index;
        logic [GEN_W-1:0]  handle_version;
        logic [REF_W-1:0]  found_ref;
    } t_result;

    typedef struct packed {
        logic load;
        logic append;
        logic pop_read;
        logic slot_read;
        logic reuse;
        logic issue;
        logic finish;
        logic reject;
    } t_ctrl;

    typedef struct packed {
        logic op_register;
        logic stack_empty;
        logic table_full;
        logic index_bad;
    } t_stat;

endpackage

`default_nettype wire

/* rtl/gha_ctrl.sv */
// ----------------------------------------------------------------------------
// gha_ctrl
// Sequencer that steps one operation through decode, table access and result.
// ----------------------------------------------------------------------------
`default_nettype none

module gha_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    output logic               o_done,
    input  wire gha_pkg::t_stat i_stat,
    output gha_pkg::t_ctrl     o_ctrl
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_POP    = 5'b00100,
        S_ISSUE  = 5'b01000,
        S_EXEC   = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_done, n_done;

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        o_ctrl  = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_ctrl.load = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.op_register) begin
                    if (!i_stat.stack_empty) begin
                        o_ctrl.pop_read = 1'b1;
                        n_state         = S_POP;
                    end else if (!i_stat.table_full) begin
                        o_ctrl.append = 1'b1;
                        n_done        = 1'b1;
                        n_state       = S_IDLE;
                    end else begin
                        o_ctrl.reject = 1'b1;
                        n_done        = 1'b1;
                        n_state       = S_IDLE;
                    end
                end else if (i_stat.index_bad) begin
                    o_ctrl.reject = 1'b1;
                    n_done        = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    o_ctrl.slot_read = 1'b1;
                    n_state          = S_EXEC;
                end
            end
            S_POP: begin
                o_ctrl.reuse = 1'b1;
                n_state      = S_ISSUE;
            end
            S_ISSUE: begin
                o_ctrl.issue = 1'b1;
                n_done       = 1'b1;
                n_state      = S_IDLE;
            end
            S_EXEC: begin
                o_ctrl.finish = 1'b1;
                n_done        = 1'b1;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule

`default_nettype wire

/* rtl/gha_dpath.sv */
// ----------------------------------------------------------------------------
// gha_dpath
// Slot tables, free stack, counters and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gha_dpath (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire gha_pkg::t_cmd    i_cmd,
    input  wire gha_pkg::t_ctrl   i_ctrl,
    output gha_pkg::t_stat        o_stat,
    output gha_pkg::t_result      o_result
);

    logic [gha_pkg::REF_W-1:0] r_ref_mem   [gha_pkg::SLOTS];
    logic [gha_pkg::GEN_W-1:0] r_gen_mem   [gha_pkg::SLOTS];
    logic [gha_pkg::IDX_W-1:0] r_stack_mem [gha_pkg::SLOTS];

    gha_pkg::t_cmd             r_cmd;
    gha_pkg::t_result          r_result, n_result;
    logic [gha_pkg::CNT_W-1:0] r_in_use, n_in_use;
    logic [gha_pkg::CNT_W-1:0] r_free, n_free;
    logic [gha_pkg::REF_W-1:0] r_ref_q;
    logic [gha_pkg::GEN_W-1:0] r_gen_q;
    logic [gha_pkg::IDX_W-1:0] r_stack_q;

    logic [gha_pkg::CNT_W-1:0] free_dec;
    logic [gha_pkg::IDX_W-1:0] gen_rd_addr;
    logic                      gen_rd_en;
    logic                      gen_wr_en;
    logic [gha_pkg::IDX_W-1:0] gen_wr_addr;
    logic [gha_pkg::GEN_W-1:0] gen_wr_data;
    logic                      ref_wr_en;
    logic [gha_pkg::IDX_W-1:0] ref_wr_addr;
    logic                      stack_wr_en;
    logic                      overflow;
    logic                      is_lookup;

    assign free_dec  = r_free - gha_pkg::CNT_W'(1);
    assign overflow  = (r_free == gha_pkg::CNT_W'(gha_pkg::SLOTS));
    assign is_lookup = (r_cmd.operation != gha_pkg::OP_EXPIRE);

    assign o_stat.op_register = (r_cmd.operation == gha_pkg::OP_REGISTER);
    assign o_stat.stack_empty = (r_free == '0);
    assign o_stat.table_full  = (r_in_use == gha_pkg::CNT_W'(gha_pkg::SLOTS));
    assign o_stat.index_bad   = ({1'b0, r_cmd.slot_index} >= r_in_use);

    assign gen_rd_en   = i_ctrl.slot_read | i_ctrl.reuse;
    assign gen_rd_addr = i_ctrl.reuse ? r_stack_q : r_cmd.slot_index;
    assign gen_wr_en   = i_ctrl.append | (i_ctrl.finish & !is_lookup & !overflow);
    assign gen_wr_addr = i_ctrl.append ? r_in_use[gha_pkg::IDX_W-1:0] : r_cmd.slot_index;
    assign gen_wr_data = i_ctrl.append ? '0 : r_gen_q + gha_pkg::GEN_W'(1);
    assign ref_wr_en   = i_ctrl.append | i_ctrl.reuse;
    assign ref_wr_addr = i_ctrl.append ? r_in_use[gha_pkg::IDX_W-1:0] : r_stack_q;
    assign stack_wr_en = i_ctrl.finish & !is_lookup & !overflow;

    always_ff @(posedge i_clk) begin
        if (gen_wr_en) begin
            r_gen_mem[gen_wr_addr] <= gen_wr_data;
        end
        if (gen_rd_en) begin
            r_gen_q <= r_gen_mem[gen_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ref_wr_en) begin
            r_ref_mem[ref_wr_addr] <= r_cmd.object_ref;
        end
        if (i_ctrl.slot_read) begin
            r_ref_q <= r_ref_mem[r_cmd.slot_index];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stack_wr_en) begin
            r_stack_mem[r_free[gha_pkg::IDX_W-1:0]] <= r_cmd.slot_index;
        end
        if (i_ctrl.pop_read) begin
            r_stack_q <= r_stack_mem[free_dec[gha_pkg::IDX_W-1:0]];
        end
    end

    always_comb begin
        n_in_use = r_in_use;
        n_free   = r_free;
        n_result = r_result;
        if (i_ctrl.append) begin
            n_in_use = r_in_use + gha_pkg::CNT_W'(1);
            n_result = '{gha_pkg::ST_OK, r_in_use[gha_pkg::IDX_W-1:0], '0, '0};
        end
        if (i_ctrl.pop_read) begin
            n_free = free_dec;
        end
        if (i_ctrl.issue) begin
            n_result = '{gha_pkg::ST_OK, r_stack_q, r_gen_q, '0};
        end
        if (i_ctrl.reject) begin
            n_result = '0;
            n_result.status = o_stat.op_register ? gha_pkg::ST_FULL : gha_pkg::ST_BAD_INDEX;
        end
        if (i_ctrl.finish) begin
            n_result = '0;
            if (is_lookup) begin
                if (r_gen_q == r_cmd.slot_version) begin
                    n_result.found_ref = r_ref_q;
                end else begin
                    n_result.status = gha_pkg::ST_STALE;
                end
            end else if (overflow) begin
                n_result.status = gha_pkg::ST_OVERFLOW;
            end else begin
                n_free = r_free + gha_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd <= i_cmd;
        end
        r_result <= n_result;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use <= '0;
            r_free   <= '0;
        end else begin
            r_in_use <= n_in_use;
            r_free   <= n_free;
        end
    end

    assign o_result = r_result;

endmodule

`default_nettype wire

/* rtl/generational_handle_allocator_unit.sv */
// ----------------------------------------------------------------------------
// generational_handle_allocator_unit
// Slot map issuing generational handles, with a LIFO free list of indices.
// ----------------------------------------------------------------------------
// The result strobe o_done rises as the sequencer finishes: an appending
// register or a rejected operation finishes in decode, expire and lookup
// after a registered slot read, and a reusing register after the registered
// free-stack and generation reads. A new beat is taken in the cycle the
// strobe shows. Synchronous reset empties the table and the free stack.
`default_nettype none

module generational_handle_allocator_unit (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire gha_pkg::t_cmd     i_cmd,
    output logic                   o_done,
    output gha_pkg::t_result       o_result
);

    gha_pkg::t_ctrl ctrl;
    gha_pkg::t_stat stat;

    gha_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    gha_dpath u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (i_cmd),
        .i_ctrl   (ctrl),
        .o_stat   (stat),
        .o_result (o_result)
    );

endmodule

`default_nettype wire
